// File: design/bt_pkg.sv
`default_nettype none
package bt_pkg;

    localparam int DEF_MAX_ATOMS = 65536;
    localparam int QUEUE_DEPTH   = 2;

    // divider geometry: dividend up to |dT| * 2^69, divisor up to tau * T
    localparam int DIV_N_W = 101;
    localparam int DIV_D_W = 56;

    localparam logic [31:0] CONV_Q40   = 32'd132240853;  // u_to_kg / k_B, 2^-40 units
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
    localparam logic [63:0] MAX_POS_Q  = 64'hEFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SQRT_START = 64'h4000_0000_0000_0000;

    localparam logic [31:0] RST_TARGET = 32'd19660800;
    localparam logic [23:0] RST_TAU    = 24'd25600;

    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_TAU    = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd2;

    localparam logic CMD_ACCUM = 1'b0;
    localparam logic CMD_SCALE = 1'b1;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_VEL    = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_CONV_LO,
        S_CONV_HI,
        S_CONV_ADD,
        S_DIV_T,
        S_CHECK,
        S_TAU,
        S_DIV_Q,
        S_ROOT_SET,
        S_ROOT,
        S_REPORT,
        S_SCALE
    } bt_state_t;

    typedef struct packed {
        logic        cmd;
        logic [23:0] mass;
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] vz;
        logic        last;
    } bt_item_t;

    typedef struct packed {
        logic     valid;
        bt_item_t item;
    } bt_head_t;

    typedef struct packed {
        logic [31:0] target;
        logic [23:0] tau;
        logic        enable;
    } bt_cfg_t;

    typedef struct packed {
        logic               go;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } bt_div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } bt_div_rsp_t;

endpackage
`default_nettype wire

// File: design/berendsen_thermostat_top.sv
`default_nettype none
// Berendsen thermostat. Words enter on start while busy is low and wait in a
// two-deep queue; an execution engine behind it drains them one at a time.
// An accumulate word runs three squarings and a split mass product on one
// shared 32x32 multiplier; a scale word yields one result. A word flagged
// last_atom then closes the pass: two multiplies, a restoring divide for T,
// a multiply, a second divide on the same divider for the root argument and
// a bit-serial square root. With no atoms the first divide is left out; zero
// temperature or a disabled thermostat skips the rest, a bad quotient the root.
// Each result is shown for one cycle with result_valid and must be taken
// then: the receiver cannot stall. Configuration is written on its own
// channel (cfg_ready is always high) and must only change while idle.
module berendsen_thermostat_top #(
    parameter int MAX_ATOMS = bt_pkg::DEF_MAX_ATOMS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command words
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [23:0]        atom_mass,
    input  wire logic signed [23:0] vel_x,
    input  wire logic signed [23:0] vel_y,
    input  wire logic signed [23:0] vel_z,
    input  wire logic               last_atom,
    // configuration
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // results
    output logic                    result_valid,
    output logic                    result_kind,
    output logic [31:0]             temperature_out,
    output logic [31:0]             factor_out,
    output logic signed [23:0]      scaled_x,
    output logic signed [23:0]      scaled_y,
    output logic signed [23:0]      scaled_z,
    output logic [1:0]              error_flags
);
    import bt_pkg::*;

    bt_item_t item;
    bt_head_t head;
    bt_cfg_t  cfg_reg;
    logic     pop;

    assign item.cmd  = command;
    assign item.mass = atom_mass;
    assign item.vx   = vel_x;
    assign item.vy   = vel_y;
    assign item.vz   = vel_z;
    assign item.last = last_atom;

    // register file; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target <= RST_TARGET;
            cfg_reg.tau    <= RST_TAU;
            cfg_reg.enable <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TARGET: cfg_reg.target <= cfg_data;
                REG_TAU:    cfg_reg.tau    <= cfg_data[23:0];
                REG_ENABLE: cfg_reg.enable <= cfg_data[0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    // front: queue between the command port and the engine
    bt_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .pop   (pop),
        .head  (head)
    );

    // back: accumulate, finalise and scale
    bt_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .pop             (pop),
        .cfg             (cfg_reg),
        .result_valid    (result_valid),
        .result_kind     (result_kind),
        .temperature_out (temperature_out),
        .factor_out      (factor_out),
        .scaled_x        (scaled_x),
        .scaled_y        (scaled_y),
        .scaled_z        (scaled_z),
        .error_flags     (error_flags)
    );
endmodule
`default_nettype wire

// File: design/bt_front.sv
`default_nettype none
module bt_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire bt_pkg::bt_item_t item,
    input  wire logic             pop,
    output bt_pkg::bt_head_t      head
);
    import bt_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bt_item_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign busy = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item;
        end
    end

`ifndef SYNTH
    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count overflow");
    a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !pop) |=> busy)
        else $error("queue lost fullness without pop");
`endif
endmodule
`default_nettype wire

// File: design/bt_div.sv
`default_nettype none
module bt_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bt_pkg::bt_div_req_t req,
    output bt_pkg::bt_div_rsp_t      rsp
);
    import bt_pkg::*;

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [DIV_N_W-1:0] n_reg;   // remaining dividend bits, quotient shifts in
    logic [DIV_D_W-1:0] d_reg;
    logic [DIV_D_W-1:0] r_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIV_D_W:0]   r_shift;
    logic [DIV_D_W:0]   r_sub;
    logic               ge;

    assign r_shift = {r_reg, n_reg[DIV_N_W-1]};
    assign r_sub   = r_shift - {1'b0, d_reg};
    assign ge      = (r_shift >= {1'b0, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_N_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            n_reg <= req.dividend;
            d_reg <= req.divisor;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? r_sub[DIV_D_W-1:0] : r_shift[DIV_D_W-1:0];
            n_reg <= {n_reg[DIV_N_W-2:0], ge};
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = n_reg;
endmodule
`default_nettype wire

// File: design/bt_back.sv
`default_nettype none
module bt_back #(
    parameter int MAX_ATOMS = bt_pkg::DEF_MAX_ATOMS
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bt_pkg::bt_head_t head,
    output logic                  pop,
    input  wire bt_pkg::bt_cfg_t  cfg,
    output logic                  result_valid,
    output logic                  result_kind,
    output logic [31:0]           temperature_out,
    output logic [31:0]           factor_out,
    output logic signed [23:0]    scaled_x,
    output logic signed [23:0]    scaled_y,
    output logic signed [23:0]    scaled_z,
    output logic [1:0]            error_flags
);
    import bt_pkg::*;

    localparam int CNT_W = $clog2(MAX_ATOMS + 1);

    bt_state_t   state_reg, state_next;
    logic [1:0]  step_reg;
    bt_item_t    item_reg;
    logic [23:0] mag_reg [3];
    logic [47:0] vsq_reg;
    logic [63:0] plo_reg;
    logic [63:0] mul_p_reg;
    logic [63:0] kinetic_sum_reg;
    logic [CNT_W-1:0] atom_count_reg;
    logic [31:0] cur_temp_reg;
    logic [31:0] scale_factor_reg;
    logic [31:0] fac_reg;
    logic [1:0]  flags_reg;
    logic [63:0] x_reg, res_reg, one_reg;

    logic        rv_reg, kind_reg;
    logic [31:0] tout_reg, fout_reg;
    logic [23:0] sx_reg, sy_reg, sz_reg;
    logic [1:0]  eflags_reg;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    bt_div_req_t  div_req;
    bt_div_rsp_t  div_rsp;

    // derived values
    logic [23:0]  tau_eff;
    logic         neg;
    logic [31:0]  dmag;
    logic [95:0]  conv_prod;
    logic [CNT_W+1:0] three_n;
    logic         over;
    logic [63:0]  q64;
    logic         bad;
    logic [72:0]  e_full;
    logic [63:0]  e_sat;
    logic [64:0]  sum_full;
    logic [63:0]  root_try;

    bt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    function automatic logic [23:0] mag24(input logic [23:0] v);
        logic [23:0] n;
        n = ~v + 24'd1;
        return v[23] ? n : v;
    endfunction

    function automatic logic [23:0] sat_scale(input logic [63:0] p, input logic negv);
        logic [25:0] m;
        logic [23:0] r;
        m = p[55:30];
        if (negv)
        begin
            r = (m > 26'h80_0000) ? 24'h80_0000 : (~m[23:0] + 24'd1);
        end
        else
        begin
            r = (m > 26'h7F_FFFF) ? 24'h7F_FFFF : m[23:0];
        end
        return r;
    endfunction

    assign tau_eff   = (cfg.tau == '0) ? 24'd1 : cfg.tau;
    assign neg       = (cfg.target < cur_temp_reg);
    assign dmag      = neg ? (cur_temp_reg - cfg.target) : (cfg.target - cur_temp_reg);
    assign conv_prod = {mul_p_reg, 32'd0} + {32'd0, plo_reg};
    assign three_n   = {1'b0, atom_count_reg, 1'b0} + {2'b00, atom_count_reg};
    assign over      = |div_rsp.quotient[DIV_N_W-1:64];
    assign q64       = div_rsp.quotient[63:0];
    assign bad       = neg ? (over || (q64 > ONE_Q60)) : (over || (q64 > MAX_POS_Q));
    assign e_full    = {mul_p_reg[47:0], 25'd0} + {9'd0, plo_reg};
    assign e_sat     = (|e_full[72:64]) ? '1 : e_full[63:0];
    assign sum_full  = {1'b0, kinetic_sum_reg} + {1'b0, e_sat};
    assign root_try  = res_reg + one_reg;
    assign mul_p     = mul_a * mul_b;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.cmd == CMD_SCALE)
                        state_next = S_SCALE;
                    else if (atom_count_reg < CNT_W'(MAX_ATOMS))
                        state_next = S_SQ;
                    else if (head.item.last)
                        state_next = S_CONV_LO;
                end
            end
            S_SQ:       if (step_reg == 2'd3) state_next = S_MUL_LO;
            S_MUL_LO:   state_next = S_MUL_HI;
            S_MUL_HI:   state_next = S_ACC;
            S_ACC:      state_next = item_reg.last ? S_CONV_LO : S_IDLE;
            S_CONV_LO:  state_next = S_CONV_HI;
            S_CONV_HI:  state_next = S_CONV_ADD;
            S_CONV_ADD: state_next = (atom_count_reg == '0) ? S_CHECK : S_DIV_T;
            S_DIV_T:    if (div_rsp.done) state_next = S_CHECK;
            S_CHECK:
                state_next = (cur_temp_reg == '0 || !cfg.enable) ? S_REPORT : S_TAU;
            S_TAU:      state_next = S_DIV_Q;
            S_DIV_Q:    if (div_rsp.done) state_next = S_ROOT_SET;
            S_ROOT_SET: state_next = bad ? S_REPORT : S_ROOT;
            S_ROOT:     if (one_reg == '0) state_next = S_REPORT;
            S_REPORT:   state_next = S_IDLE;
            S_SCALE:    if (step_reg == 2'd3) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // control outputs: queue pop, shared multiplier operands, divider launch
    always_comb
    begin
        pop              = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        div_req.go       = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (state_reg)
            S_IDLE:
                pop = head.valid;
            S_SQ:
            begin
                case (step_reg)
                    2'd0:    mul_a = {8'd0, mag_reg[0]};
                    2'd1:    mul_a = {8'd0, mag_reg[1]};
                    2'd2:    mul_a = {8'd0, mag_reg[2]};
                    default: mul_a = '0;
                endcase
                mul_b = mul_a;
            end
            S_MUL_LO:
            begin
                mul_a = {8'd0, item_reg.mass};
                mul_b = {7'd0, vsq_reg[24:0]};
            end
            S_MUL_HI:
            begin
                mul_a = {8'd0, item_reg.mass};
                mul_b = {9'd0, vsq_reg[47:25]};
            end
            S_CONV_LO:
            begin
                mul_a = kinetic_sum_reg[31:0];
                mul_b = CONV_Q40;
            end
            S_CONV_HI:
            begin
                mul_a = kinetic_sum_reg[63:32];
                mul_b = CONV_Q40;
            end
            S_CONV_ADD:
            begin
                div_req.go       = (atom_count_reg != '0);
                div_req.dividend = {57'd0, conv_prod[91:48]};
                div_req.divisor  = DIV_D_W'(three_n);
            end
            S_CHECK:
            begin
                mul_a = cur_temp_reg;
                mul_b = {8'd0, tau_eff};
            end
            S_TAU:
            begin
                div_req.go       = 1'b1;
                div_req.dividend = {dmag, 69'd0};
                div_req.divisor  = mul_p_reg[DIV_D_W-1:0];
            end
            S_SCALE:
            begin
                case (step_reg)
                    2'd0:    mul_a = {8'd0, mag_reg[0]};
                    2'd1:    mul_a = {8'd0, mag_reg[1]};
                    2'd2:    mul_a = {8'd0, mag_reg[2]};
                    default: mul_a = '0;
                endcase
                mul_b = scale_factor_reg;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // control and kept state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_reg         <= '0;
            kinetic_sum_reg  <= '0;
            atom_count_reg   <= '0;
            cur_temp_reg     <= '0;
            scale_factor_reg <= ONE_Q30;
            rv_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == S_REPORT) ||
                         (state_reg == S_SCALE && step_reg == 2'd3);
            if (state_reg == S_IDLE)
                step_reg <= '0;
            else if (state_reg == S_SQ || state_reg == S_SCALE)
                step_reg <= step_reg + 2'd1;
            case (state_reg)
                S_ACC:
                begin
                    kinetic_sum_reg <= sum_full[64] ? '1 : sum_full[63:0];
                    atom_count_reg  <= atom_count_reg + 1'b1;
                end
                S_CONV_ADD:
                    if (atom_count_reg == '0) cur_temp_reg <= '0;
                S_DIV_T:
                begin
                    if (div_rsp.done)
                        cur_temp_reg <= (|div_rsp.quotient[DIV_N_W-1:32]) ? '1
                                      : div_rsp.quotient[31:0];
                end
                S_REPORT:
                begin
                    scale_factor_reg <= fac_reg;
                    kinetic_sum_reg  <= '0;
                    atom_count_reg   <= '0;
                end
                default:
                begin
                    cur_temp_reg <= cur_temp_reg;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_p_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                item_reg   <= head.item;
                mag_reg[0] <= mag24(head.item.vx);
                mag_reg[1] <= mag24(head.item.vy);
                mag_reg[2] <= mag24(head.item.vz);
                vsq_reg    <= '0;
            end
            S_SQ:
                if (step_reg != 2'd0) vsq_reg <= vsq_reg + mul_p_reg[47:0];
            S_MUL_HI:
                plo_reg <= mul_p_reg;
            S_CONV_LO:
            begin
                flags_reg <= '0;
                fac_reg   <= ONE_Q30;
            end
            S_CONV_HI:
                plo_reg <= mul_p_reg;
            S_CHECK:
                if (cur_temp_reg == '0) flags_reg[0] <= 1'b1;
            S_ROOT_SET:
            begin
                if (bad)
                begin
                    if (neg) flags_reg[1] <= 1'b1;
                    else     fac_reg      <= '1;
                end
                x_reg   <= neg ? (ONE_Q60 - q64) : (ONE_Q60 + q64);
                res_reg <= '0;
                one_reg <= SQRT_START;
            end
            S_ROOT:
            begin
                if (one_reg == '0)
                begin
                    fac_reg <= res_reg[31:0];
                end
                else
                begin
                    if (x_reg >= root_try)
                    begin
                        x_reg   <= x_reg - root_try;
                        res_reg <= (res_reg >> 1) + one_reg;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    one_reg <= one_reg >> 2;
                end
            end
            S_REPORT:
            begin
                kind_reg   <= KIND_REPORT;
                tout_reg   <= cur_temp_reg;
                fout_reg   <= fac_reg;
                sx_reg     <= '0;
                sy_reg     <= '0;
                sz_reg     <= '0;
                eflags_reg <= flags_reg;
            end
            S_SCALE:
            begin
                case (step_reg)
                    2'd1: sx_reg <= sat_scale(mul_p_reg, item_reg.vx[23]);
                    2'd2: sy_reg <= sat_scale(mul_p_reg, item_reg.vy[23]);
                    2'd3:
                    begin
                        sz_reg     <= sat_scale(mul_p_reg, item_reg.vz[23]);
                        kind_reg   <= KIND_VEL;
                        tout_reg   <= cur_temp_reg;
                        fout_reg   <= scale_factor_reg;
                        eflags_reg <= '0;
                    end
                    default: sx_reg <= sx_reg;
                endcase
            end
            default:
            begin
                plo_reg <= plo_reg;
            end
        endcase
    end

    assign result_valid    = rv_reg;
    assign result_kind     = kind_reg;
    assign temperature_out = tout_reg;
    assign factor_out      = fout_reg;
    assign scaled_x        = sx_reg;
    assign scaled_y        = sy_reg;
    assign scaled_z        = sz_reg;
    assign error_flags     = eflags_reg;

`ifndef SYNTH
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |=> !rv_reg)
        else $error("result strobe held for two cycles");
    a_div_idle_go: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.go |-> !div_rsp.busy)
        else $error("divider launched while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        atom_count_reg <= CNT_W'(MAX_ATOMS))
        else $error("atom count beyond limit");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != S_IDLE || $past(head.item.cmd) == CMD_ACCUM)
        else $error("scale word popped without leaving idle");
`endif
endmodule
`default_nettype wire
